[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion helpers for the I2C write sequencer checkers
// Shared macro forms for clocked concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2cmw_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmw_pkg - shared types and constants
// Phase codes, the queued item format and fixed widths of the sequencer.
// ----------------------------------------------------------------------------
package i2cmw_pkg;

  localparam int unsigned HOLD_W = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5;
  localparam logic [2:0] BIT_LAST = 3'd7;     // eighth bit of a byte
  localparam logic [7:0] MSB_MASK = 8'h80;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START     = 4'd1,
    PH_BIT_LOW   = 4'd2,
    PH_BIT_HIGH  = 4'd3,
    PH_ACK_LOW   = 4'd4,
    PH_ACK_HIGH  = 4'd5,
    PH_WAIT      = 4'd6,
    PH_STOP_LOW  = 4'd7,
    PH_STOP_HIGH = 4'd8,
    PH_STOP_END  = 4'd9
  } phase_t;

  // One classified input beat as it sits in the queue.
  typedef struct packed {
    logic       is_byte;
    logic [6:0] device_address;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       sda_sample;
  } item_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

[rtl/i2cmw_front.sv]
// ----------------------------------------------------------------------------
// i2cmw_front - input beat acceptance, classification and two-entry queue
// Decodes the beat kind from tuser and buffers items for the sequencer.
// ----------------------------------------------------------------------------
module i2cmw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // device_address[6:0], data_byte[14:7], sda_sample[15]
  input  logic                in_tlast,   // last_byte
  input  logic                in_tuser,   // cmd: 0 tick, 1 queue a byte
  output i2cmw_pkg::q_head_t  q_head,
  input  logic                q_pop
);

  i2cmw_pkg::item_t mem_r [2];
  i2cmw_pkg::item_t in_item;
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       push, pop;

  always_comb begin
    in_item.is_byte        = in_tuser;
    in_item.device_address = in_tdata[6:0];
    in_item.data_byte      = in_tdata[14:7];
    in_item.last_byte      = in_tlast;
    in_item.sda_sample     = in_tdata[15];
  end

  assign in_tready   = (count_r != 2'd2);
  assign push        = in_tvalid & in_tready;
  assign pop         = q_pop & (count_r != 2'd0);
  assign q_head.valid = (count_r != 2'd0);
  assign q_head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

[rtl/i2cmw_seq.sv]
// ----------------------------------------------------------------------------
// i2cmw_seq - bus phase sequencer and result register
// Steps one queued item per cycle unless the held result beat is not taken.
// ----------------------------------------------------------------------------
module i2cmw_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  i2cmw_pkg::q_head_t  q_head,
  output logic                q_pop,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata
);

  i2cmw_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic        nack_flag_r, nack_flag_nxt;
  logic [7:0]  pending_byte_r, pending_byte_nxt;
  logic        pending_valid_r, pending_valid_nxt;
  logic        pending_last_r, pending_last_nxt;
  logic        current_last_r, current_last_nxt;
  logic [6:0]  target_address_r, target_address_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [15:0] hold_r;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [7:0]  out_tdata_r, out_tdata_nxt;

  logic [15:0] hold_eff, tick_inc;
  logic        high_done, cur_bit, sda_in, tick_beat, byte_beat;
  logic        dropped, fin;

  assign q_pop     = q_head.valid & (~out_tvalid_r | out_tready);
  assign tick_beat = q_pop & ~q_head.item.is_byte;
  assign byte_beat = q_pop & q_head.item.is_byte;
  assign sda_in    = q_head.item.sda_sample;

  assign hold_eff  = (hold_r == 16'd0) ? 16'd1 : hold_r;
  assign tick_inc  = tick_count_r + 16'd1;
  assign high_done = (tick_inc >= hold_eff);
  assign cur_bit   = |((i2cmw_pkg::MSB_MASK >> bit_index_r[2:0]) & shift_byte_r);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (tick_beat) begin
      unique case (phase_r)
        i2cmw_pkg::PH_START:     phase_nxt = i2cmw_pkg::PH_BIT_LOW;
        i2cmw_pkg::PH_BIT_LOW:   phase_nxt = i2cmw_pkg::PH_BIT_HIGH;
        i2cmw_pkg::PH_BIT_HIGH: begin
          if (high_done) begin
            phase_nxt = (bit_index_r[2:0] == i2cmw_pkg::BIT_LAST) ?
                        i2cmw_pkg::PH_ACK_LOW : i2cmw_pkg::PH_BIT_LOW;
          end
        end
        i2cmw_pkg::PH_ACK_LOW:   phase_nxt = i2cmw_pkg::PH_ACK_HIGH;
        i2cmw_pkg::PH_ACK_HIGH: begin
          if (high_done) begin
            priority if (sda_in || current_last_r) begin
              phase_nxt = i2cmw_pkg::PH_STOP_LOW;
            end else if (pending_valid_r) begin
              phase_nxt = i2cmw_pkg::PH_BIT_LOW;
            end else begin
              phase_nxt = i2cmw_pkg::PH_WAIT;
            end
          end
        end
        i2cmw_pkg::PH_WAIT: begin
          if (pending_valid_r) phase_nxt = i2cmw_pkg::PH_BIT_LOW;
        end
        i2cmw_pkg::PH_STOP_LOW:  phase_nxt = i2cmw_pkg::PH_STOP_HIGH;
        i2cmw_pkg::PH_STOP_HIGH: phase_nxt = i2cmw_pkg::PH_STOP_END;
        i2cmw_pkg::PH_STOP_END:  phase_nxt = i2cmw_pkg::PH_IDLE;
        default: begin
          phase_nxt = pending_valid_r ? i2cmw_pkg::PH_START : i2cmw_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Datapath, pending slot, driven levels and result beat.
  always_comb begin
    bit_index_nxt      = bit_index_r;
    shift_byte_nxt     = shift_byte_r;
    tick_count_nxt     = tick_count_r;
    nack_flag_nxt      = nack_flag_r;
    pending_byte_nxt   = pending_byte_r;
    pending_valid_nxt  = pending_valid_r;
    pending_last_nxt   = pending_last_r;
    current_last_nxt   = current_last_r;
    target_address_nxt = target_address_r;
    scl_nxt            = scl_r;
    sda_nxt            = sda_r;
    dropped            = 1'b0;
    fin                = 1'b0;

    if (byte_beat) begin
      if (pending_valid_r) begin
        dropped = 1'b1;
      end else begin
        if (phase_r == i2cmw_pkg::PH_IDLE || current_last_r) begin
          target_address_nxt = q_head.item.device_address;
        end
        pending_byte_nxt  = q_head.item.data_byte;
        pending_last_nxt  = q_head.item.last_byte;
        pending_valid_nxt = 1'b1;
      end
    end else if (tick_beat) begin
      unique case (phase_r)
        i2cmw_pkg::PH_START: begin
          scl_nxt        = 1'b1;
          sda_nxt        = 1'b0;
          shift_byte_nxt = {target_address_r, 1'b0};
          bit_index_nxt  = 4'd0;
          tick_count_nxt = 16'd0;
        end
        i2cmw_pkg::PH_BIT_LOW: begin
          scl_nxt        = 1'b0;
          sda_nxt        = cur_bit;
          tick_count_nxt = 16'd0;
        end
        i2cmw_pkg::PH_BIT_HIGH: begin
          scl_nxt        = 1'b1;
          sda_nxt        = cur_bit;
          tick_count_nxt = high_done ? 16'd0 : tick_inc;
          if (high_done) begin
            bit_index_nxt = (bit_index_r[2:0] == i2cmw_pkg::BIT_LAST) ?
                            4'd0 : bit_index_r + 4'd1;
          end
        end
        i2cmw_pkg::PH_ACK_LOW: begin
          scl_nxt        = 1'b0;
          sda_nxt        = 1'b1;
          tick_count_nxt = 16'd0;
        end
        i2cmw_pkg::PH_ACK_HIGH: begin
          scl_nxt        = 1'b1;
          sda_nxt        = 1'b1;
          tick_count_nxt = high_done ? 16'd0 : tick_inc;
          if (high_done) begin
            priority if (sda_in) begin
              // NACK: drop a byte still queued for this transaction.
              nack_flag_nxt    = 1'b1;
              if (!current_last_r) pending_valid_nxt = 1'b0;
              current_last_nxt = 1'b1;
            end else if (current_last_r) begin
              current_last_nxt = current_last_r;
            end else if (pending_valid_r) begin
              shift_byte_nxt    = pending_byte_r;
              current_last_nxt  = pending_last_r;
              pending_valid_nxt = 1'b0;
              bit_index_nxt     = 4'd0;
              tick_count_nxt    = 16'd0;
            end else begin
              current_last_nxt = current_last_r;
            end
          end
        end
        i2cmw_pkg::PH_WAIT: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
          if (pending_valid_r) begin
            shift_byte_nxt    = pending_byte_r;
            current_last_nxt  = pending_last_r;
            pending_valid_nxt = 1'b0;
            bit_index_nxt     = 4'd0;
            tick_count_nxt    = 16'd0;
          end
        end
        i2cmw_pkg::PH_STOP_LOW: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        i2cmw_pkg::PH_STOP_HIGH: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        i2cmw_pkg::PH_STOP_END: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
          fin     = 1'b1;
        end
        default: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
          if (pending_valid_r) begin
            nack_flag_nxt    = 1'b0;
            current_last_nxt = 1'b0;
          end
        end
      endcase
    end

    out_tdata_nxt  = {1'b0, fin & nack_flag_r, fin, dropped,
                      (phase_nxt != i2cmw_pkg::PH_IDLE), ~pending_valid_nxt,
                      sda_nxt, scl_nxt};
    out_tvalid_nxt = q_pop ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= i2cmw_pkg::PH_IDLE;
      bit_index_r      <= 4'd0;
      shift_byte_r     <= 8'd0;
      tick_count_r     <= 16'd0;
      nack_flag_r      <= 1'b0;
      pending_valid_r  <= 1'b0;
      pending_last_r   <= 1'b0;
      current_last_r   <= 1'b0;
      target_address_r <= 7'd0;
      scl_r            <= 1'b1;
      sda_r            <= 1'b1;
      hold_r           <= i2cmw_pkg::HOLD_RESET;
      out_tvalid_r     <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      bit_index_r      <= bit_index_nxt;
      shift_byte_r     <= shift_byte_nxt;
      tick_count_r     <= tick_count_nxt;
      nack_flag_r      <= nack_flag_nxt;
      pending_valid_r  <= pending_valid_nxt;
      pending_last_r   <= pending_last_nxt;
      current_last_r   <= current_last_nxt;
      target_address_r <= target_address_nxt;
      scl_r            <= scl_nxt;
      sda_r            <= sda_nxt;
      if (cfg_wr_en) hold_r <= cfg_wr_data;
      out_tvalid_r     <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pending_byte_r <= pending_byte_nxt;
    if (q_pop) out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[rtl/i2c_master_write_sequencer.sv]
// An accepted beat enters the queue; its result is registered as the sequencer pops it.
// Throughput: one beat per cycle; one queued item stepped each cycle unless out_ stalls.
// A two-entry queue parts intake from the sequencer; the result register parts it from out_.
// Reset: synchronous on rst_n low; clears queue, phase goes idle, SCL/SDA read high,
// high_hold_ticks returns to 5. No clearing pass is needed.
// ----------------------------------------------------------------------------
// i2c_master_write_sequencer - I2C master write transaction sequencer
// Tick beats step the bus through start, address, data, acknowledge and stop;
// byte beats fill a single pending slot. Each beat yields one result beat.
// ----------------------------------------------------------------------------
module i2c_master_write_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // device_address[6:0], data_byte[14:7], sda_sample[15]
  input  logic        in_tlast,   // last_byte
  input  logic        in_tuser,   // cmd: 0 tick with bus sample, 1 queue a byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // scl_level[0], sda_level[1], wants_byte[2], busy_res[3],
                                  // byte_dropped[4], finished[5], nack_seen[6], zero[7]
  // configuration: high_hold_ticks
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // Queue head offered to the sequencer, and its pop strobe.
  i2cmw_pkg::q_head_t q_head;
  logic               q_pop;

  // Front: accept and classify beats, hold them in a short queue.
  i2cmw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  // Back: advance the bus phase per item; hold the result until out_ takes it.
  i2cmw_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

[rtl/i2cmw_checker.sv]
// ----------------------------------------------------------------------------
// i2cmw_checker - port-level assertions for the write sequencer
// Watches the result stream for consistent flag combinations.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cmw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // Hold a stalled result beat.
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // Finish the stop with both lines released and the bus no longer busy.
  `CHK_ASSERT(a_fin_idle, clk, rst_n, (out_tvalid && out_tdata[5]) |-> (out_tdata[0] && out_tdata[1] && !out_tdata[3]), "finished without released idle bus")

  // Report a NACK only on the finishing beat.
  `CHK_ASSERT(a_nack_fin, clk, rst_n, (out_tvalid && out_tdata[6]) |-> out_tdata[5], "nack_seen outside finished beat")

  // Drop a byte only while the slot stays full.
  `CHK_ASSERT(a_drop_full, clk, rst_n, (out_tvalid && out_tdata[4]) |-> (!out_tdata[2] && !out_tdata[5]), "byte_dropped with empty slot or on a tick")

endmodule

bind i2c_master_write_sequencer i2cmw_checker u_i2cmw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[sim/tb_i2c_master_write_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_write_sequencer - self-checking bench for the I2C write sequencer
// Drives tick and byte beats on the input stream, models the bus sequencer
// beat by beat, and checks every result beat against the model. Random beats
// follow well-formed write transactions with random addresses, data, ACK/NACK
// and missing-byte gaps, plus a share of noise beats. Both stream sides idle
// in random bursts, and high_hold_ticks sweeps through several settings.
// ----------------------------------------------------------------------------
module tb_i2c_master_write_sequencer;

  // beat kinds on in_tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  // cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // cycles to let the pipeline settle after the last result of a phase
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic       cmd;
    logic [6:0] addr;
    logic [7:0] data;
    logic       last;
    logic       sda;
  } bus_beat_t;

  // mirrors out_tdata, bit 0 is scl_level
  typedef struct packed {
    logic pad;
    logic nack_seen;
    logic finished;
    logic byte_dropped;
    logic busy;
    logic wants_byte;
    logic sda_level;
    logic scl_level;
  } bus_result_t;

  // Tracks the sequencer state and queues the result each accepted beat causes.
  class write_seq_scoreboard;
    logic [15:0]          hold_ticks;
    i2cmw_pkg::phase_t    phase;
    logic [3:0]           bit_idx;
    logic [7:0]           shift_reg;
    logic [15:0]          tick_cnt;
    logic                 nack_flag;
    logic [7:0]           pend_byte;
    logic                 pend_valid;
    logic                 pend_last;
    logic                 cur_last;
    logic [6:0]           target_addr;
    logic                 scl_drv;
    logic                 sda_drv;
    bus_result_t          expected_q[$];
    int                   errors;

    function new();
      hold_ticks  = i2cmw_pkg::HOLD_RESET;
      phase       = i2cmw_pkg::PH_IDLE;
      bit_idx     = '0;
      shift_reg   = '0;
      tick_cnt    = '0;
      nack_flag   = 1'b0;
      pend_byte   = '0;
      pend_valid  = 1'b0;
      pend_last   = 1'b0;
      cur_last    = 1'b0;
      target_addr = '0;
      scl_drv     = 1'b1;
      sda_drv     = 1'b1;
      errors      = 0;
    endfunction

    function void set_hold(logic [15:0] value);
      hold_ticks = value;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function logic data_bit();
      return |((i2cmw_pkg::MSB_MASK >> bit_idx[2:0]) & shift_reg);
    endfunction

    // Count one high tick; a hold of zero behaves as one.
    function logic high_elapsed();
      logic [15:0] span;
      span = (hold_ticks == '0) ? 16'd1 : hold_ticks;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= span) begin
        tick_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void load_pending();
      shift_reg  = pend_byte;
      cur_last   = pend_last;
      pend_valid = 1'b0;
      bit_idx    = '0;
      tick_cnt   = '0;
      phase      = i2cmw_pkg::PH_BIT_LOW;
    endfunction

    function void note_beat(bus_beat_t b);
      bus_result_t r;
      r = '0;
      if (b.cmd == CMD_BYTE) begin
        if (pend_valid) begin
          r.byte_dropped = 1'b1;
        end else begin
          // a byte opens a new transaction once the current one has its last byte
          if (phase == i2cmw_pkg::PH_IDLE || cur_last) target_addr = b.addr;
          pend_byte  = b.data;
          pend_last  = b.last;
          pend_valid = 1'b1;
        end
      end else begin
        case (phase)
          i2cmw_pkg::PH_START: begin
            scl_drv   = 1'b1;
            sda_drv   = 1'b0;
            shift_reg = {target_addr, 1'b0};
            bit_idx   = '0;
            tick_cnt  = '0;
            phase     = i2cmw_pkg::PH_BIT_LOW;
          end
          i2cmw_pkg::PH_BIT_LOW: begin
            scl_drv  = 1'b0;
            sda_drv  = data_bit();
            tick_cnt = '0;
            phase    = i2cmw_pkg::PH_BIT_HIGH;
          end
          i2cmw_pkg::PH_BIT_HIGH: begin
            scl_drv = 1'b1;
            sda_drv = data_bit();
            if (high_elapsed()) begin
              if (bit_idx[2:0] == i2cmw_pkg::BIT_LAST) begin
                bit_idx = '0;
                phase   = i2cmw_pkg::PH_ACK_LOW;
              end else begin
                bit_idx = bit_idx + 4'd1;
                phase   = i2cmw_pkg::PH_BIT_LOW;
              end
            end
          end
          i2cmw_pkg::PH_ACK_LOW: begin
            scl_drv  = 1'b0;
            sda_drv  = 1'b1;
            tick_cnt = '0;
            phase    = i2cmw_pkg::PH_ACK_HIGH;
          end
          i2cmw_pkg::PH_ACK_HIGH: begin
            scl_drv = 1'b1;
            sda_drv = 1'b1;
            if (high_elapsed()) begin
              if (b.sda) begin
                // NACK: drop a queued byte of this transaction and go to stop
                nack_flag = 1'b1;
                if (!cur_last) pend_valid = 1'b0;
                cur_last = 1'b1;
                phase    = i2cmw_pkg::PH_STOP_LOW;
              end else if (cur_last) begin
                phase = i2cmw_pkg::PH_STOP_LOW;
              end else if (pend_valid) begin
                load_pending();
              end else begin
                phase = i2cmw_pkg::PH_WAIT;
              end
            end
          end
          i2cmw_pkg::PH_WAIT: begin
            scl_drv = 1'b0;
            sda_drv = 1'b1;
            if (pend_valid) load_pending();
          end
          i2cmw_pkg::PH_STOP_LOW: begin
            scl_drv = 1'b0;
            sda_drv = 1'b0;
            phase   = i2cmw_pkg::PH_STOP_HIGH;
          end
          i2cmw_pkg::PH_STOP_HIGH: begin
            scl_drv = 1'b1;
            sda_drv = 1'b0;
            phase   = i2cmw_pkg::PH_STOP_END;
          end
          i2cmw_pkg::PH_STOP_END: begin
            scl_drv     = 1'b1;
            sda_drv     = 1'b1;
            r.finished  = 1'b1;
            r.nack_seen = nack_flag;
            phase       = i2cmw_pkg::PH_IDLE;
          end
          default: begin
            scl_drv = 1'b1;
            sda_drv = 1'b1;
            phase   = i2cmw_pkg::PH_IDLE;
            if (pend_valid) begin
              nack_flag = 1'b0;
              cur_last  = 1'b0;
              phase     = i2cmw_pkg::PH_START;
            end
          end
        endcase
      end
      r.scl_level  = scl_drv;
      r.sda_level  = sda_drv;
      r.wants_byte = !pend_valid;
      r.busy       = (phase != i2cmw_pkg::PH_IDLE);
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, got %0b", field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [7:0] raw);
      bus_result_t got;
      bus_result_t want;
      got = raw;
      if (expected_q.size() == 0) begin
        $error("result beat %h with no expectation waiting", raw);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("scl_level", want.scl_level, got.scl_level);
      compare("sda_level", want.sda_level, got.sda_level);
      compare("wants_byte", want.wants_byte, got.wants_byte);
      compare("busy_res", want.busy, got.busy);
      compare("byte_dropped", want.byte_dropped, got.byte_dropped);
      compare("finished", want.finished, got.finished);
      compare("nack_seen", want.nack_seen, got.nack_seen);
      compare("pad", want.pad, got.pad);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // device_address[6:0], data_byte[14:7], sda_sample[15]
  logic        in_tlast;   // last_byte
  logic        in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // scl, sda, wants_byte, busy, dropped, finished, nack, zero
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  write_seq_scoreboard sb = new();

  bit quiet;        // no idling on either side
  int rx_hold_off;  // cycles the result side must hold off, counted by the sink
  int bytes_left;   // bytes still to queue for the current planned transaction
  int idle_cycles;

  i2c_master_write_sequencer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bus_beat_t make_beat(logic cmd, logic [6:0] addr, logic [7:0] data,
                                          logic last, logic sda);
    bus_beat_t b;
    b.cmd  = cmd;
    b.addr = addr;
    b.data = data;
    b.last = last;
    b.sda  = sda;
    return b;
  endfunction

  // Offer one beat, with an occasional idle burst ahead of it, and hold it
  // until the block takes it.
  task automatic send_beat(bus_beat_t b);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = b.cmd;
    in_tlast  = b.last;
    in_tdata  = {b.sda, b.data, b.addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_beat(b);
  endtask

  // Pick the next beat from the modeled state: mostly well-formed transactions
  // (bytes queued while the slot is free, always in the wait phase, else at random;
  // ACK on the sampled tick), with some noise beats mixed in.
  task automatic pick_beat(output bus_beat_t b);
    b = make_beat(CMD_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 15) == 0) begin
      b.cmd = 1'($urandom_range(0, 1));
      return;
    end
    if (!sb.pend_valid && bytes_left == 0) bytes_left = $urandom_range(1, 3);
    if (!sb.pend_valid && bytes_left > 0 &&
        (sb.phase == i2cmw_pkg::PH_WAIT || $urandom_range(0, 5) == 0)) begin
      b.cmd  = CMD_BYTE;
      b.last = (bytes_left == 1);
      bytes_left--;
    end else if (sb.phase == i2cmw_pkg::PH_ACK_HIGH) begin
      // mostly ACK; a NACK now and then aborts the transaction
      b.sda = ($urandom_range(0, 9) == 0);
    end
  endtask

  task automatic run_random(int count);
    bus_beat_t b;
    repeat (count) begin
      pick_beat(b);
      send_beat(b);
    end
  endtask

  // Stop offering, wait until every expected result is in, let the pipeline
  // settle, then write high_hold_ticks.
  task automatic drain_and_write(logic [15:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_hold(value);
  endtask

  // Directed opening at the reset hold: idle ticks with both SDA levels, an
  // opening byte with all-ones address and data, a refused byte with all-zero
  // address and data, then the start condition and the first address bits.
  task automatic run_directed();
    int n;
    send_beat(make_beat(CMD_TICK, 7'h00, 8'h00, 1'b0, 1'b1));
    send_beat(make_beat(CMD_TICK, 7'h7F, 8'hFF, 1'b1, 1'b0));
    send_beat(make_beat(CMD_BYTE, 7'h7F, 8'hFF, 1'b0, 1'b0));
    send_beat(make_beat(CMD_BYTE, 7'h00, 8'h00, 1'b1, 1'b1));
    for (n = 0; n < 20; n++) begin
      send_beat(make_beat(CMD_TICK, 7'h00, 8'h00, 1'b0, n[0]));
    end
  endtask

  // Result sink: random hold-off bursts, one long hold-off on request, and a
  // check of every accepted beat.
  initial begin : result_sink
    int burst;
    burst      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_off > 0) begin
        out_tready = 1'b0;
        rx_hold_off--;
      end else if (burst > 0) begin
        out_tready = 1'b0;
        burst--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        burst      = $urandom_range(0, 6);
      end else begin
        out_tready = 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata);
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[i2c_master_write_sequencer] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    in_tuser    = CMD_TICK;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    quiet       = 1'b0;
    rx_hold_off = 0;
    bytes_left  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    // zero hold acts as one
    drain_and_write(16'd0);
    run_random(180);
    drain_and_write(16'd1);
    run_random(180);
    // long hold-off on the result side while beats keep coming
    drain_and_write(16'd3);
    rx_hold_off = 80;
    run_random(180);
    // largest hold: the bus parks in a high phase while bytes pile up
    drain_and_write(16'hFFFF);
    run_random(100);
    drain_and_write(16'd2);
    run_random(180);
    drain_and_write(16'd7);
    run_random(130);
    // final stretch with no idling on either side
    drain_and_write(16'd1);
    quiet = 1'b1;
    run_random(150);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[i2c_master_write_sequencer] OK");
    end else begin
      $display("[i2c_master_write_sequencer] ERROR");
    end
    $finish;
  end

endmodule

[i2c_master_write_sequencer.f]
+incdir+rtl
rtl/i2cmw_pkg.sv
rtl/i2cmw_front.sv
rtl/i2cmw_seq.sv
rtl/i2c_master_write_sequencer.sv
rtl/i2cmw_checker.sv
sim/tb_i2c_master_write_sequencer.sv
